### hdl/lbs_pkg.sv
package lbs_pkg;

  // transaction kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_SKIN  = 1'b1;

  localparam int COORD_W  = 32;
  localparam int WEIGHT_W = 16;
  localparam int SLOTS    = 4;
  localparam int ELEMS    = 12;

  // queued work between front and back
  typedef struct packed {
    logic                     skin;
    logic [11:0]              addr;
    logic signed [31:0]       value;
    logic signed [31:0]       px;
    logic signed [31:0]       py;
    logic signed [31:0]       pz;
    logic [31:0]              joints;
    logic [63:0]              weights;
  } job_t;

  // finished result
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               zero_weight;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

### hdl/lbs_front.sv
// two-entry input queue towards the back end
module lbs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lbs_pkg::job_t     in_job,
  output logic              q_valid,
  input  logic              q_ready,
  output lbs_pkg::job_t     q_job
);

  lbs_pkg::job_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_job    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_job;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hdl/lbs_divider.sv
// restoring divider: floor(n / d), d > 0, one quotient bit a cycle
module lbs_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [18:0]        den,
  output logic               done,
  output logic signed [63:0] quo
);

  logic [63:0] mag_r, q_r;
  logic [19:0] rem_r;
  logic [18:0] den_r;
  logic        neg_r, busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [19:0] trial;
  logic [63:0] mag_in;
  logic [64:0] qneg;

  assign mag_in = num[63] ? ~num : num;   // -(n+1) for negative n
  assign trial  = {rem_r[18:0], mag_r[63]} - {1'b0, den_r};
  // floor(n/d) for n<0 is -(floor((-n-1)/d)) - 1
  assign qneg   = {1'b0, ~q_r};
  assign quo    = neg_r ? qneg[63:0] : q_r;
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        mag_r  <= mag_in;
        neg_r  <= num[63];
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        mag_r <= {mag_r[62:0], 1'b0};
        if (!trial[19]) begin
          rem_r <= trial;
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[18:0], mag_r[63]};
          q_r   <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/lbs_back.sv
// palette memory, transform sequencer and normalisation
module lbs_back #(
  parameter int MAX_JOINTS = 256,
  parameter int INFLUENCES = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  lbs_pkg::job_t q_job,
  output logic          res_valid,
  input  logic          res_ready,
  output lbs_pkg::res_t res
);

  localparam int DEPTH = MAX_JOINTS * lbs_pkg::ELEMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int JW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int NI    = (INFLUENCES < lbs_pkg::SLOTS) ? INFLUENCES : lbs_pkg::SLOTS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r;

  logic [31:0] pal_r [DEPTH];
  logic [31:0] rd_r;

  lbs_pkg::job_t job_r;
  logic [1:0]  inf_r;
  logic [1:0]  axis_r;
  logic [1:0]  term_r;
  logic [1:0]  div_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] hi_r, lo_r;
  logic signed [63:0] num_r [3];
  logic [18:0]        wsum_r;
  logic signed [31:0] out_r [3];
  logic               zw_r;
  logic               rv_r;
  logic               mul_v_r;

  logic [JW-1:0]      joint;
  logic [AW-1:0]      rd_addr;
  logic [15:0]        w_cur;
  logic signed [31:0] pos_sel;
  logic signed [63:0] q_fl, c_full;
  logic signed [31:0] c_sat;
  logic               div_start, div_done;
  logic signed [63:0] div_num, div_quo;
  logic [63:0]        weights_sh;

  // joint index wrapped into the palette by compare and subtract
  function automatic logic [JW-1:0] wrap_joint(input logic [7:0] idx);
    logic [15:0] v;
    v = {8'd0, idx};
    for (int s = 7; s >= 0; s--) begin
      if (v >= 16'(MAX_JOINTS << s)) begin
        v = v - 16'(MAX_JOINTS << s);
      end
    end
    return v[JW-1:0];
  endfunction

  assign weights_sh = job_r.weights >> (16 * inf_r);
  assign joint      = wrap_joint(job_r.joints[8*inf_r +: 8]);
  assign w_cur      = weights_sh[15:0];
  assign rd_addr    = AW'(32'(joint) * lbs_pkg::ELEMS + 32'(axis_r) * 4 + 32'(term_r));

  always_comb begin
    case (term_r)
      2'd0:    pos_sel = job_r.px;
      2'd1:    pos_sel = job_r.py;
      default: pos_sel = job_r.pz;
    endcase
  end

  // palette memory, one port each way
  always_ff @(posedge clk) begin
    if (q_valid && q_ready && (q_job.skin == lbs_pkg::ACT_WRITE) &&
        (32'(q_job.addr) < DEPTH)) begin
      pal_r[q_job.addr[AW-1:0]] <= q_job.value;
    end
    rd_r <= pal_r[rd_addr];
  end

  assign q_ready   = (state_r == S_IDLE);
  assign res_valid = rv_r;
  assign res.x     = out_r[0];
  assign res.y     = out_r[1];
  assign res.z     = out_r[2];
  assign res.zero_weight = zw_r;

  // exact coordinate: hi + translation + floor(lo / 2^16), lo holds the low fractions
  assign q_fl   = prod_r >>> 16;
  assign c_full = hi_r + 64'(signed'(rd_r)) + (lo_r >>> 16);
  assign c_sat  = lbs_pkg::sat32(c_full);

  assign div_num   = (num_r[div_r] <<< 1) + 64'(wsum_r);
  assign div_start = (state_r == S_DIV);

  lbs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   ({wsum_r[17:0], 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer: reads one palette element at a time, three terms then translation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rv_r    <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      if (rv_r && res_ready && (state_r != S_OUT)) begin
        rv_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid && q_job.skin == lbs_pkg::ACT_SKIN) begin
            job_r    <= q_job;
            inf_r    <= '0;
            axis_r   <= '0;
            term_r   <= '0;
            hi_r     <= '0;
            lo_r     <= '0;
            wsum_r   <= '0;
            num_r[0] <= '0;
            num_r[1] <= '0;
            num_r[2] <= '0;
            state_r  <= S_READ;
          end
        end
        S_READ: begin
          // address presented, data lands next cycle
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (mul_v_r) begin
            hi_r <= hi_r + q_fl;
            lo_r <= lo_r + (prod_r - (q_fl <<< 16));
          end
          if (term_r == 2'd3) begin
            mul_v_r <= 1'b0;
            state_r <= S_ACC;
          end else begin
            prod_r  <= 64'(signed'(rd_r)) * 64'(pos_sel);
            term_r  <= term_r + 2'd1;
            mul_v_r <= 1'b1;
            state_r <= S_READ;
          end
        end
        S_ACC: begin
          if (mul_v_r) begin
            // fold the last product before the translation is added
            hi_r    <= hi_r + q_fl;
            lo_r    <= lo_r + (prod_r - (q_fl <<< 16));
            mul_v_r <= 1'b0;
          end else begin
            num_r[axis_r] <= num_r[axis_r] + 64'(signed'({1'b0, w_cur})) * 64'(c_sat);
            hi_r   <= '0;
            lo_r   <= '0;
            term_r <= '0;
            if (axis_r == 2'd2) begin
              axis_r <= '0;
              wsum_r <= wsum_r + 19'(w_cur);
              if (32'(inf_r) == NI - 1) begin
                div_r   <= '0;
                state_r <= S_DIV;
              end else begin
                inf_r   <= inf_r + 2'd1;
                state_r <= S_READ;
              end
            end else begin
              axis_r  <= axis_r + 2'd1;
              state_r <= S_READ;
            end
          end
        end
        S_DIV: begin
          // the previous result must leave before the outputs are overwritten
          if (!rv_r || res_ready) begin
            if (wsum_r == '0) begin
              out_r[0] <= '0;
              out_r[1] <= '0;
              out_r[2] <= '0;
              zw_r     <= 1'b1;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (div_done) begin
            out_r[div_r] <= lbs_pkg::sat32(div_quo);
            zw_r         <= 1'b0;
            if (div_r == 2'd2) begin
              state_r <= S_OUT;
            end else begin
              div_r   <= div_r + 2'd1;
              state_r <= S_DIV;
            end
          end
        end
        S_OUT: begin
          rv_r    <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/linear_blend_skinning.sv
// Four-influence vertex skinning engine. A write transaction (tuser = 0) stores one
// palette element at joint*12 + axis*4 + term; a skin transaction (tuser = 1) yields
// one result, the weight-normalised blend of the position transformed by up to four
// joint matrices. A write is taken while the back end is idle and leaves it idle. With
// four influences a vertex streams 48 palette elements through the single memory
// read port and the shared multiplier, then runs three bit-serial divisions for
// normalisation; the transaction is taken in the idle state and the result is
// presented from an output state. A zero weight sum skips the divisions.
// Normalisation waits until the previous result has been taken. A two-entry queue
// decouples input acceptance from the skinning sequencer.
module linear_blend_skinning #(
  parameter int MAX_JOINTS = 256,
  parameter int INFLUENCES = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // palette_address, palette_value, pos_x, pos_y, pos_z, joint_indices, blend_weights
  input  logic [239:0] in_tdata,
  // action
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z
  output logic [95:0]  out_tdata,
  // zero_weight
  output logic         out_tuser
);

  lbs_pkg::job_t in_job, q_job;
  lbs_pkg::res_t res;
  logic          q_valid, q_ready;

  assign in_job.skin    = in_tuser;
  assign in_job.addr    = in_tdata[11:0];
  assign in_job.value   = in_tdata[43:12];
  assign in_job.px      = in_tdata[75:44];
  assign in_job.py      = in_tdata[107:76];
  assign in_job.pz      = in_tdata[139:108];
  assign in_job.joints  = in_tdata[171:140];
  assign in_job.weights = in_tdata[235:172];

  lbs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_job   (in_job),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_job    (q_job)
  );

  lbs_back #(
    .MAX_JOINTS (MAX_JOINTS),
    .INFLUENCES (INFLUENCES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_job     (q_job),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.z, res.y, res.x};
  assign out_tuser = res.zero_weight;

endmodule
